[rtl/rrr_pkg.sv]
// Shared types and constants of the return risk ratio block.
// Used by rrr_arith and return_risk_ratios; depends on nothing else.
package rrr_pkg;

  // Default series length limit and fraction width of the Q format.
  localparam int unsigned MAX_SAMPLES_DEF = 4096;
  localparam int unsigned FRAC_BITS_DEF   = 16;

  // Width of the saturating sample sum and its limits.
  localparam int unsigned SUM_W = 45;

  // Width of the shared unit's operands and result.
  localparam int unsigned WIDE_W = 128;

  // sqrt(252) in Q4.28, rounded.
  localparam logic [63:0] SQRT252_Q28 = 64'd4261280758;

  // Operations of the shared arithmetic unit.
  localparam logic [1:0] OP_MUL  = 2'd0;
  localparam logic [1:0] OP_DIV  = 2'd1;
  localparam logic [1:0] OP_SQRT = 2'd2;

  // Request to the shared unit.
  typedef struct packed {
    logic       go;
    logic [1:0] op;
  } rrr_req_t;

endpackage

[rtl/return_risk_ratios.sv]
// Top level of the return risk ratio block: accumulators, sequencer, APB registers.
// Depends on rrr_pkg and rrr_arith.
//
// Each return word is taken when start is high and busy is low; a sample
// that is not the last of its series keeps busy high through states S_SQA,
// S_SQB and S_SQC after it is taken, so the next sample waits for them,
// set by the single 32x32 squaring multiplier used twice per sample. The
// last sample then starts the ratio computation on one shared bit-serial
// unit (multiply, divide and square root). The result word appears for one
// cycle with out_valid and must be captured then; it cannot be held off.
module return_risk_ratios #(
  parameter int unsigned MAX_SAMPLES = rrr_pkg::MAX_SAMPLES_DEF,
  parameter int unsigned FRAC_BITS   = rrr_pkg::FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic signed [31:0] in_return_sample,
  input  logic               in_last_sample,
  output logic               out_valid,
  output logic signed [31:0] out_sharpe_out,
  output logic signed [31:0] out_sortino_out,
  output logic [30:0]        out_volatility_out,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import rrr_pkg::*;

  localparam int unsigned CNT_W = $clog2(MAX_SAMPLES + 1);

  // Sequencer state codes.
  localparam logic [4:0] S_IDLE = 5'd0;
  localparam logic [4:0] S_SQA  = 5'd1;
  localparam logic [4:0] S_SQB  = 5'd2;
  localparam logic [4:0] S_SQC  = 5'd3;
  localparam logic [4:0] S_CHK  = 5'd4;
  localparam logic [4:0] S_NQ   = 5'd5;
  localparam logic [4:0] S_S2   = 5'd6;
  localparam logic [4:0] S_DN   = 5'd7;
  localparam logic [4:0] S_VAR  = 5'd8;
  localparam logic [4:0] S_SD   = 5'd9;
  localparam logic [4:0] S_VOL  = 5'd10;
  localparam logic [4:0] S_NC   = 5'd11;
  localparam logic [4:0] S_NUM  = 5'd12;
  localparam logic [4:0] S_MK   = 5'd13;
  localparam logic [4:0] S_DEN  = 5'd14;
  localparam logic [4:0] S_RDIV = 5'd15;
  localparam logic [4:0] S_SCHK = 5'd16;
  localparam logic [4:0] S_MDIV = 5'd17;
  localparam logic [4:0] S_DSQ  = 5'd18;
  localparam logic [4:0] S_OUT  = 5'd19;

  logic [4:0]              state_r, state_nxt;
  logic signed [31:0]      rf_r, mar_r;
  logic signed [31:0]      smp_r;
  logic                    last_r, en_r, short_r;
  logic [CNT_W-1:0]        cnt_r, scnt_r;
  logic signed [SUM_W-1:0] sum_r;
  logic [63:0]             sq_sum_r, ssq_sum_r, prod_r;
  logic [WIDE_W-1:0]       w0_r, w1_r;
  logic [63:0]             var_r;
  logic [31:0]             dev_r;
  logic                    which_r, neg_r, issued_r;
  logic signed [31:0]      c_r;
  logic signed [CNT_W+32:0] nc_r;
  logic signed [31:0]      sharpe_r, sortino_r;
  logic [30:0]             vol_r;

  // Configuration writes; the low address bits are not decoded.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rf_r  <= '0;
      mar_r <= '0;
    end else if (psel && penable && pwrite) begin
      if (paddr[2]) mar_r <= pwdata;
      else          rf_r  <= pwdata;
    end
  end
  assign prdata = paddr[2] ? mar_r : rf_r;
  assign pready = 1'b1;

  // Per-sample terms: magnitude, shortfall below the target, squaring multiplier.
  logic [31:0]        smag32, dmag32, mul_in;
  logic signed [32:0] dsig;
  logic               below;
  logic [63:0]        sq_prod;
  logic signed [SUM_W:0] sum_t;
  logic [64:0]        sqa_t, ssa_t;
  assign smag32  = smp_r[31] ? 32'(-{smp_r[31], smp_r}) : smp_r;
  assign dsig    = 33'(mar_r) - 33'(smp_r);
  assign dmag32  = dsig[31:0];
  assign below   = smp_r < mar_r;
  assign mul_in  = (state_r == S_SQA) ? smag32 : dmag32;
  assign sq_prod = mul_in * mul_in;
  assign sum_t   = (SUM_W + 1)'(sum_r) + (SUM_W + 1)'(smp_r);
  assign sqa_t   = {1'b0, sq_sum_r} + {1'b0, prod_r};
  assign ssa_t   = {1'b0, ssq_sum_r} + {1'b0, prod_r};

  // Interface of the shared unit.
  rrr_req_t          u_req;
  logic [WIDE_W-1:0] u_a, u_b, u_res;
  logic              u_done, op_state;

  // Terms of the final computation.
  logic [SUM_W-1:0]        ssum_mag;
  logic signed [63:0]      sum64, num_s;
  logic [63:0]             cnt64, n252;
  logic [WIDE_W-1:0]       vol_t;
  logic [32:0]             lim;
  logic [31:0]             qm, qv;
  assign ssum_mag = sum_r[SUM_W-1] ? SUM_W'(-sum_r) : sum_r;
  assign sum64    = 64'(sum_r);
  assign num_s    = (sum64 <<< 8) - (sum64 <<< 2) - 64'(nc_r);
  assign cnt64    = 64'(cnt_r);
  assign n252     = (cnt64 << 8) - (cnt64 << 2);
  assign vol_t    = (u_res + (WIDE_W'(1) << 27)) >> 28;
  assign lim      = neg_r ? 33'h0_8000_0000 : 33'h0_7FFF_FFFF;
  assign qm       = ((|u_res[WIDE_W-1:32]) || ({1'b0, u_res[31:0]} > lim)) ?
                    lim[31:0] : u_res[31:0];
  assign qv       = neg_r ? -qm : qm;

  // Shared unit request by state.
  always_comb begin
    op_state = 1'b1;
    u_req.op = OP_MUL;
    u_a      = '0;
    u_b      = '0;
    case (state_r)
      S_NQ:   begin u_a = WIDE_W'(cnt_r); u_b = WIDE_W'(sq_sum_r); end
      S_S2:   begin u_a = WIDE_W'(ssum_mag); u_b = WIDE_W'(ssum_mag); end
      S_DN:   begin u_a = WIDE_W'(cnt_r); u_b = WIDE_W'(cnt_r - CNT_W'(1)); end
      S_VAR:  begin u_req.op = OP_DIV; u_a = w0_r; u_b = w1_r; end
      S_SD:   begin u_req.op = OP_SQRT; u_a = WIDE_W'(var_r); end
      S_VOL:  begin u_a = WIDE_W'(dev_r); u_b = WIDE_W'(SQRT252_Q28); end
      S_MK:   begin u_a = w0_r; u_b = WIDE_W'(SQRT252_Q28); end
      S_DEN:  begin u_a = WIDE_W'(n252); u_b = WIDE_W'(dev_r); end
      S_RDIV: begin u_req.op = OP_DIV; u_a = w0_r; u_b = w1_r; end
      S_MDIV: begin
        u_req.op = OP_DIV;
        u_a      = WIDE_W'(ssq_sum_r);
        u_b      = WIDE_W'(scnt_r - CNT_W'(1));
      end
      S_DSQ:  begin u_req.op = OP_SQRT; u_a = WIDE_W'(var_r); end
      default: op_state = 1'b0;
    endcase
    u_req.go = op_state && !issued_r;
  end

  rrr_arith u_arith (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (u_req),
    .opa   (u_a),
    .opb   (u_b),
    .done  (u_done),
    .res   (u_res)
  );

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (start) state_nxt = S_SQA;
      S_SQA:  state_nxt = S_SQB;
      S_SQB:  state_nxt = S_SQC;
      S_SQC:  state_nxt = last_r ? S_CHK : S_IDLE;
      S_CHK:  state_nxt = (cnt_r < CNT_W'(2)) ? S_OUT : S_NQ;
      S_NQ:   if (u_done) state_nxt = S_S2;
      S_S2:   if (u_done) state_nxt = (w0_r > u_res) ? S_DN : S_SD;
      S_DN:   if (u_done) state_nxt = S_VAR;
      S_VAR:  if (u_done) state_nxt = S_SD;
      S_SD:   if (u_done) state_nxt = (u_res == '0) ? S_SCHK : S_VOL;
      S_VOL:  if (u_done) state_nxt = S_NC;
      S_NC:   state_nxt = S_NUM;
      S_NUM:  state_nxt = S_MK;
      S_MK:   if (u_done) state_nxt = S_DEN;
      S_DEN:  if (u_done) state_nxt = S_RDIV;
      S_RDIV: if (u_done) state_nxt = which_r ? S_OUT : S_SCHK;
      S_SCHK: state_nxt = (scnt_r >= CNT_W'(2)) ? S_MDIV : S_OUT;
      S_MDIV: if (u_done) state_nxt = S_DSQ;
      S_DSQ:  if (u_done) state_nxt = (u_res == '0) ? S_OUT : S_NC;
      S_OUT:  state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // Control registers and accumulators.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      issued_r  <= 1'b0;
      cnt_r     <= '0;
      scnt_r    <= '0;
      sum_r     <= '0;
      sq_sum_r  <= '0;
      ssq_sum_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (u_req.go) issued_r <= 1'b1;
      else if (u_done) issued_r <= 1'b0;
      case (state_r)
        S_SQA: if (en_r) begin
          cnt_r <= cnt_r + CNT_W'(1);
          // The two top bits of the wide sum differ only when it left the range.
          if (sum_t[SUM_W] != sum_t[SUM_W-1])
            sum_r <= sum_t[SUM_W] ? {1'b1, {(SUM_W - 1){1'b0}}} :
                                    {1'b0, {(SUM_W - 1){1'b1}}};
          else
            sum_r <= sum_t[SUM_W-1:0];
        end
        S_SQB: if (en_r) sq_sum_r <= sqa_t[64] ? '1 : sqa_t[63:0];
        S_SQC: if (short_r) begin
          scnt_r    <= scnt_r + CNT_W'(1);
          ssq_sum_r <= ssa_t[64] ? '1 : ssa_t[63:0];
        end
        S_OUT: begin
          cnt_r     <= '0;
          scnt_r    <= '0;
          sum_r     <= '0;
          sq_sum_r  <= '0;
          ssq_sum_r <= '0;
        end
        default: ;
      endcase
    end
  end

  // Admission flags of a sample, taken before the count moves.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      en_r    <= 1'b0;
      short_r <= 1'b0;
    end else if (state_r == S_IDLE && start) begin
      en_r    <= cnt_r < CNT_W'(MAX_SAMPLES);
      short_r <= 1'b0;
    end else if (state_r == S_SQA) begin
      short_r <= en_r && below;
    end
  end

  // Datapath registers of the sample and the final computation.
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: if (start) begin
        smp_r  <= in_return_sample;
        last_r <= in_last_sample;
      end
      S_SQA: prod_r <= sq_prod;
      S_SQB: prod_r <= sq_prod;
      S_CHK: begin
        sharpe_r  <= '0;
        sortino_r <= '0;
        vol_r     <= '0;
        which_r   <= 1'b0;
      end
      S_NQ:  if (u_done) w0_r <= u_res;
      S_S2:  if (u_done) begin
        if (w0_r > u_res) w0_r <= w0_r - u_res;
        else              var_r <= '0;
      end
      S_DN:  if (u_done) w1_r <= u_res;
      S_VAR: if (u_done) var_r <= (|u_res[WIDE_W-1:64]) ? '1 : u_res[63:0];
      S_SD:  if (u_done) dev_r <= u_res[31:0];
      S_VOL: if (u_done) begin
        vol_r <= (|vol_t[WIDE_W-1:31]) ? '1 : vol_t[30:0];
        c_r   <= rf_r;
      end
      S_NC:  nc_r <= $signed({1'b0, cnt_r}) * c_r;
      S_NUM: begin
        neg_r <= num_s[63];
        w0_r  <= WIDE_W'(num_s[63] ? -num_s : num_s);
      end
      S_MK:  if (u_done) w0_r <= u_res << FRAC_BITS;
      S_DEN: if (u_done) begin
        w1_r <= u_res << 28;
        w0_r <= w0_r + (u_res << 27);
      end
      S_RDIV: if (u_done) begin
        if (which_r) sortino_r <= qv;
        else         sharpe_r  <= qv;
      end
      S_MDIV: if (u_done) var_r <= u_res[63:0];
      S_DSQ: if (u_done) begin
        dev_r   <= u_res[31:0];
        which_r <= 1'b1;
        c_r     <= mar_r;
      end
      default: ;
    endcase
  end

  // Result word and handshake.
  assign busy               = state_r != S_IDLE;
  assign out_valid          = state_r == S_OUT;
  assign out_sharpe_out     = sharpe_r;
  assign out_sortino_out    = sortino_r;
  assign out_volatility_out = vol_r;

endmodule

[rtl/rrr_arith.sv]
// Shared bit-serial arithmetic unit: shift-add multiply, restoring divide
// and integer square root. Depends on rrr_pkg.
module rrr_arith (
  input  logic                        clk,
  input  logic                        rst_n,
  input  rrr_pkg::rrr_req_t           req,
  input  logic [rrr_pkg::WIDE_W-1:0]  opa,
  input  logic [rrr_pkg::WIDE_W-1:0]  opb,
  output logic                        done,
  output logic [rrr_pkg::WIDE_W-1:0]  res
);
  import rrr_pkg::*;

  logic              busy_r;
  logic              done_r;
  logic [1:0]        op_r;
  logic [6:0]        cnt_r;
  logic [WIDE_W-1:0] acc_r;
  logic [WIDE_W-1:0] x_r;
  logic [WIDE_W-1:0] y_r;
  logic [WIDE_W:0]   rem_r;
  logic [63:0]       bit_r;

  logic [WIDE_W:0]   rem_t;
  logic [63:0]       trial;

  assign rem_t = {rem_r[WIDE_W-1:0], x_r[WIDE_W-1]};
  assign trial = y_r[63:0] + bit_r;

  // Control: load on a request, count down the steps, pulse done at the end.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      op_r   <= OP_MUL;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.go) begin
        busy_r <= 1'b1;
        op_r   <= req.op;
        case (req.op)
          OP_MUL:  cnt_r <= 7'd63;
          OP_DIV:  cnt_r <= 7'd127;
          default: cnt_r <= 7'd31;
        endcase
      end else if (busy_r) begin
        cnt_r <= cnt_r - 7'd1;
        if (cnt_r == 7'd0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Datapath: one step of the selected operation per cycle.
  always_ff @(posedge clk) begin
    if (req.go) begin
      case (req.op)
        OP_MUL: begin
          acc_r <= '0;
          x_r   <= opa;
          y_r   <= {64'd0, opb[63:0]};
        end
        OP_DIV: begin
          rem_r <= '0;
          x_r   <= opa;
          y_r   <= opb;
        end
        default: begin
          acc_r <= {64'd0, opa[63:0]};
          y_r   <= '0;
          bit_r <= 64'h4000_0000_0000_0000;
        end
      endcase
    end else if (busy_r) begin
      case (op_r)
        OP_MUL: begin
          if (y_r[0]) acc_r <= acc_r + x_r;
          x_r <= {x_r[WIDE_W-2:0], 1'b0};
          y_r <= {1'b0, y_r[WIDE_W-1:1]};
        end
        OP_DIV: begin
          if (rem_t >= {1'b0, y_r}) begin
            rem_r <= rem_t - {1'b0, y_r};
            x_r   <= {x_r[WIDE_W-2:0], 1'b1};
          end else begin
            rem_r <= rem_t;
            x_r   <= {x_r[WIDE_W-2:0], 1'b0};
          end
        end
        default: begin
          if (acc_r[63:0] >= trial) begin
            acc_r <= {64'd0, acc_r[63:0] - trial};
            y_r   <= {64'd0, ({1'b0, y_r[63:1]} + bit_r)};
          end else begin
            y_r   <= {64'd0, 1'b0, y_r[63:1]};
          end
          bit_r <= {2'b00, bit_r[63:2]};
        end
      endcase
    end
  end

  assign done = done_r;

  // Result view by operation.
  always_comb begin
    case (op_r)
      OP_MUL:  res = acc_r;
      OP_DIV:  res = x_r;
      default: res = {64'd0, y_r[63:0]};
    endcase
  end

endmodule

[rtl/rrr_chk.sv]
// Port-level checker for return_risk_ratios, bound to the top level.
// Depends on the top level's ports only.
module rrr_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        start,
  input logic        busy,
  input logic        out_valid,
  input logic [31:0] out_sharpe_out,
  input logic [30:0] out_volatility_out,
  input logic        pready
);

  // A result word is only shown while the block is working on a series.
  a_valid_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy) else $error("result shown while idle");

  // Each result word is a single-cycle strobe.
  a_valid_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("result strobe longer than a cycle");

  // An accepted word makes the block busy.
  a_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy) else $error("word taken but block not busy");

  // Zero volatility means an undefined Sharpe ratio, which reads as zero.
  a_vol_sharpe: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_volatility_out == 31'd0) |-> out_sharpe_out == 32'd0)
    else $error("Sharpe ratio without volatility");

  // The register port never inserts wait states.
  a_pready: assert property (@(posedge clk) disable iff (!rst_n)
    pready) else $error("pready low");

endmodule

bind return_risk_ratios rrr_chk u_rrr_chk (
  .clk                (clk),
  .rst_n              (rst_n),
  .start              (start),
  .busy               (busy),
  .out_valid          (out_valid),
  .out_sharpe_out     (out_sharpe_out),
  .out_volatility_out (out_volatility_out),
  .pready             (pready)
);
